FILE: rtl/assert_macros.svh
// Assertion helpers used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_SAME(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

FILE: rtl/sns_pkg.sv
// ----------------------------------------------------------------------------
// sns_pkg
// Constants, round table and shared types of the nonce search block.
// ----------------------------------------------------------------------------
package sns_pkg;

  localparam int DIGITS = 10;
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
  localparam logic [30:0] LIMIT_RESET = 31'd1048576;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic done;
    logic zero_byte;
  } core_status_t;

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,
      32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,
      32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,
      32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
      32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
      32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,
      32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
      32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,
      32'hc67178f2};
    round_k = k[t];
  endfunction

endpackage

FILE: rtl/sns_sha_core.sv
// ----------------------------------------------------------------------------
// sns_sha_core
// One-block SHA-256 compression, one round per cycle; reports whether the
// first digest byte is zero.
// ----------------------------------------------------------------------------
module sns_sha_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [511:0]         block,
  output sns_pkg::core_status_t status
);

  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic        running;
  logic        fin;

  logic [31:0] s0, s1, ch, maj, t1, t2, w_new, ws0, ws1;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + sns_pkg::round_k(rnd) + w[0];
    s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + maj;
    ws0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    ws1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = ws1 + w[9] + ws0 + w[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin <= 1'b0;
      rnd <= '0;
      status <= '0;
    end else begin
      status.done <= fin;
      status.zero_byte <= ((sns_pkg::init_h(3'd0) + v[0]) >> 24) == 32'd0;
      fin <= running && (rnd == 6'd63);
      if (start) begin
        running <= 1'b1;
        rnd <= '0;
      end else if (running) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Datapath: load on start, advance one round per running cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= sns_pkg::init_h(3'(i));
      end
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[511 - 32*i -: 32];
      end
    end else if (running) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
  end

endmodule

FILE: rtl/sha256_nonce_search_top.sv
// ----------------------------------------------------------------------------
// sha256_nonce_search_top
// Proof-of-work nonce search over one-block SHA-256 digests.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to launch a search for last_proof. The block
// converts last_proof to decimal text, one digit per cycle, then for each
// nonce builds "<last_proof><nonce>" in ASCII and hashes it with a shared
// SHA-256 round unit, one round per cycle. Each nonce goes through a limit
// check, a load, 64 rounds and a digest test, in that order. The result shows
// on proof_value and found for exactly one cycle with done high; there is no
// way to stall it, so capture it then. found = 1 reports the winning nonce
// plus one; found = 0 reports the attempt count, equal to attempt_limit. Write
// attempt_limit (reset 1048576) through cfg_valid/cfg_data only while idle.
module sha256_nonce_search_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] last_proof,
  output logic        done,
  output logic [30:0] proof_value,
  output logic        found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_CHECK, S_HASH, S_WAIT
  } state_t;

  state_t      state;
  logic [30:0] attempt_limit;
  logic [31:0] nonce_counter;
  logic [30:0] conv_val;
  logic [3:0]  pd [sns_pkg::DIGITS];   // prefix digits, least significant first
  logic [3:0]  plen;
  logic [3:0]  nd [sns_pkg::DIGITS];   // nonce digits in BCD
  logic [3:0]  nd_next [sns_pkg::DIGITS];
  logic [3:0]  nlen;
  logic [3:0]  nlen_next;
  logic [63:0] prod;
  logic [30:0] quot;
  logic [3:0]  digit;
  logic [511:0] block;
  logic        core_start;
  sns_pkg::core_status_t core_stat;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);

  // Divide by ten through the reciprocal; remainder by shift-and-add.
  always_comb begin
    prod = {33'd0, conv_val} * {32'd0, sns_pkg::RECIP10};
    quot = {2'b00, prod[63:35]};
    digit = 4'(conv_val - ((quot << 3) + (quot << 1)));
  end

  // Advance the decimal nonce by one; grow the length on carry out.
  always_comb begin
    logic carry;
    carry = 1'b1;
    nlen_next = nlen;
    for (int i = 0; i < sns_pkg::DIGITS; i++) begin
      if (carry) begin
        if (nd[i] == 4'd9) begin
          nd_next[i] = 4'd0;
        end else begin
          nd_next[i] = nd[i] + 4'd1;
          carry = 1'b0;
          if (4'(i) >= nlen) begin
            nlen_next = 4'(i + 1);
          end
        end
      end else begin
        nd_next[i] = nd[i];
      end
    end
  end

  // Assemble the padded message block; a 20-byte text puts the pad at byte 20.
  always_comb begin
    logic [4:0] mlen;
    logic [4:0] pi;
    logic [4:0] ni;
    mlen = {1'b0, plen} + {1'b0, nlen};
    block = '0;
    for (int i = 0; i < 21; i++) begin
      pi = {1'b0, plen} - 5'd1 - 5'(i);
      ni = mlen - 5'd1 - 5'(i);
      if (5'(i) < {1'b0, plen}) begin
        block[511 - 8*i -: 8] = sns_pkg::ASCII_ZERO | {4'd0, pd[pi[3:0]]};
      end else if (5'(i) < mlen) begin
        block[511 - 8*i -: 8] = sns_pkg::ASCII_ZERO | {4'd0, nd[ni[3:0]]};
      end else if (5'(i) == mlen) begin
        block[511 - 8*i -: 8] = sns_pkg::PAD_BYTE;
      end
    end
    block[7:0] = {mlen, 3'd0};
  end

  sns_sha_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (core_start),
    .block  (block),
    .status (core_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      attempt_limit <= sns_pkg::LIMIT_RESET;
      nonce_counter <= '0;
      done <= 1'b0;
      found <= 1'b0;
      proof_value <= '0;
      core_start <= 1'b0;
      plen <= '0;
      nlen <= 4'd1;
    end else begin
      done <= 1'b0;
      core_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        attempt_limit <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            conv_val <= last_proof;
            plen <= '0;
            nonce_counter <= '0;
            nlen <= 4'd1;
            for (int i = 0; i < sns_pkg::DIGITS; i++) begin
              nd[i] <= 4'd0;
            end
            state <= S_CONV;
          end
        end
        S_CONV: begin
          pd[plen] <= digit;
          plen <= plen + 4'd1;
          conv_val <= quot;
          if (quot == 31'd0) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (nonce_counter >= {1'b0, attempt_limit}) begin
            proof_value <= nonce_counter[30:0];
            found <= 1'b0;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            core_start <= 1'b1;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (core_stat.done) begin
            nonce_counter <= nonce_counter + 32'd1;
            if (core_stat.zero_byte) begin
              proof_value <= 31'(nonce_counter + 32'd1);
              found <= 1'b1;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              nd <= nd_next;
              nlen <= nlen_next;
              state <= S_CHECK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sns_checker.sv
// ----------------------------------------------------------------------------
// sns_checker
// Port-level checks of the nonce search handshake and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sns_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")
  `ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without a search")
  `ASSERT_NEXT(a_done_single, done, !done, "result repeated")

endmodule

bind sha256_nonce_search_top sns_checker u_sns_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

FILE: verif/sha256_nonce_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_nonce_search_checker
// Watches the search, config and result channels, predicts every result
// and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module sha256_nonce_search_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [30:0] last_proof,
  input  logic        done,
  input  logic [30:0] proof_value,
  input  logic        found,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [30:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          hits,
  output int          misses
);

  typedef struct {
    logic [30:0] proof;
    logic        hit;
  } search_result_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [30:0]    limit_q;
  search_result_t expected_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Append decimal text of v at pos, return new length.
  function automatic int append_decimal(ref logic [7:0] msg [64], input int pos,
                                        input logic [31:0] v);
    logic [7:0] digits [10];
    int n;
    n = 0;
    do begin
      digits[n] = 8'h30 + 8'(v % 10);
      v = v / 10;
      n++;
    end while (v != 0);
    while (n > 0) begin
      n--;
      msg[pos] = digits[n];
      pos++;
    end
    return pos;
  endfunction

  // First digest word of the one-block SHA-256 of msg[0:len-1].
  function automatic logic [31:0] digest_head(input logic [7:0] msg [64], input int len);
    logic [7:0]  blk [64];
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, maj;
    for (int i = 0; i < 64; i++) blk[i] = (i < len) ? msg[i] : 8'h00;
    blk[len] = 8'h80;
    blk[62] = 8'((len * 8) >> 8);
    blk[63] = 8'(len * 8);
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = START_H[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        s0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
        s1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
        w[t&15] = w[t&15] + s0 + s1 + w[(t-7)&15];
      end
      s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + ROUND_K[t] + w[t&15];
      s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2  = s0 + maj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    return START_H[0] + v[0];
  endfunction

  function automatic search_result_t search_nonce(input logic [30:0] prev,
                                                  input logic [30:0] lim);
    logic [7:0]  msg [64];
    logic [31:0] nonce;
    logic [31:0] head;
    int          prefix, len;
    search_result_t r;
    prefix = append_decimal(msg, 0, {1'b0, prev});
    nonce = 0;
    r.hit = 1'b0;
    while (nonce < {1'b0, lim}) begin
      len = append_decimal(msg, prefix, nonce);
      nonce++;
      head = digest_head(msg, len);
      if (head[31:24] == 8'h00) begin
        r.hit = 1'b1;
        break;
      end
    end
    r.proof = nonce[30:0];
    return r;
  endfunction

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    hits = 0;
    misses = 0;
  end

  always @(posedge clk) begin
    search_result_t exp_r;
    if (rst) begin
      limit_q <= sns_pkg::LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) limit_q <= cfg_data;
      if (start && !busy) begin
        expected_q.push_back(search_nonce(last_proof, limit_q));
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected word proof_value=%0d found=%0b", proof_value, found));
        end else begin
          exp_r = expected_q.pop_front();
          if (proof_value !== exp_r.proof)
            report($sformatf("proof_value %0d, want %0d", proof_value, exp_r.proof));
          if (found !== exp_r.hit)
            report($sformatf("found %0b, want %0b", found, exp_r.hit));
          if (exp_r.hit) hits++;
          else misses++;
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

FILE: verif/sha256_nonce_search_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_nonce_search_top_tb
// Drives proof searches under several attempt limits and lets the checker
// compare every reported proof against its own SHA-256 search.
// ----------------------------------------------------------------------------
module sha256_nonce_search_top_tb;

  localparam int  CYCLE_LIMIT = 12_000_000;
  localparam logic [30:0] LIMIT_MAX = 31'h7FFF_FFFF;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [30:0] last_proof;
  logic        done;
  logic [30:0] proof_value;
  logic        found;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_data;

  int errors, pending, hits, misses;
  int cycles;
  int words_sent;

  sha256_nonce_search_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .last_proof(last_proof),
    .done(done), .proof_value(proof_value), .found(found),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  sha256_nonce_search_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .last_proof(last_proof),
    .done(done), .proof_value(proof_value), .found(found),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .hits(hits), .misses(misses)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Abort on a hung block; the bound covers far more tries than any run needs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sha256_nonce_search_top] ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
    return $urandom_range(0, 3);
  endfunction

  // Issue one search word; hold start high so a zero gap chains the next one.
  task automatic send_search(input logic [30:0] prev);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    last_proof <= prev;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // Drain every outstanding result, then let the block settle. First let the
  // checker's pending count take in the word just accepted.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Write attempt_limit while the block is idle.
  task automatic write_limit(input logic [30:0] lim);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [30:0] random_proof();
    if ($urandom_range(0, 1) == 0) return 31'($urandom_range(0, 999));
    return 31'($urandom);
  endfunction

  initial begin
    logic [30:0] lim;
    cycles     = 0;
    words_sent = 0;
    rst        = 1'b1;
    start      = 1'b0;
    last_proof = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limit: extremes of last_proof.
    send_search(31'd0);
    send_search(LIMIT_MAX);

    // Zero limit: no nonce tried at all.
    write_limit(31'd0);
    send_search(31'd12345);
    send_search(31'h2AAA_AAAA);

    // Limit of one: almost always not found.
    write_limit(31'd1);
    send_search(31'd0);
    send_search(31'h5555_5555);
    send_search(31'd100);

    // Small limit: limit reached mixed with early hits.
    write_limit(31'd3);
    for (int i = 0; i < 6; i++) send_search(31'(i * 7));

    // Widest limit: searches end on a hit.
    write_limit(LIMIT_MAX);
    send_search(31'd1);
    send_search(31'h4000_0000);
    send_search(31'h2AAA_AAAA);
    send_search(31'h5555_5555);
    send_search(31'd9);

    // Random phases, each under its own limit; drain before every change.
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 2))
        0: lim = 31'($urandom_range(1, 600));
        1: lim = sns_pkg::LIMIT_RESET;
        default: lim = 31'($urandom_range(200, 2000));
      endcase
      write_limit(lim);
      for (int i = 0; i < 20; i++) send_search(random_proof());
    end

    drain();
    repeat (100) @(posedge clk);

    $display("Searches issued: %0d; proofs found: %0d, limit reached: %0d.",
             words_sent, hits, misses);
    $display("Limits covered: reset, zero, one, three, maximum and random ones.");
    if (errors == 0) begin
      $display("[sha256_nonce_search_top] OK");
    end else begin
      $display("[sha256_nonce_search_top] ERROR");
    end
    $finish;
  end

endmodule
